// ===== rtl/bhpq_pkg.sv =====
// Package for the binary max-heap priority queue.
// Holds the entry type, opcodes, status codes, controller states, the command and
// status structs between controller and datapath, and the entry ordering function.
`default_nettype none

package bhpq_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int PRIO_W       = 32;
  localparam int TIE_W        = 64;
  localparam int ENTRY_CNT_W  = 11;
  localparam int STAT_W       = 2;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TIE_W-1:0]  tie;
  } entry_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEC,
    ST_UP_CHK,
    ST_UP_CMP,
    ST_POP_WT,
    ST_DN_CHK,
    ST_DN_SEL,
    ST_DN_CMP,
    ST_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic set_full;
    logic set_empty;
    logic push_init;
    logic pop_init;
    logic rd_parent;
    logic up_move;
    logic wr_mov;
    logic pop_load;
    logic rd_kids;
    logic dn_sel;
    logic dn_move;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_pop;
    logic full;
    logic empty;
    logic pos_zero;
    logic up_stop;
    logic kid_out;
    logic dn_stop;
  } sts_t;

  // true when a ranks strictly below b: lower priority, or equal and larger tie key
  function automatic logic ranks_below(entry_t a, entry_t b);
    logic lt;
    logic eq;
    lt = $signed(a.prio) < $signed(b.prio);
    eq = a.prio == b.prio;
    return lt || (eq && (a.tie > b.tie));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/binary_heap_priority_queue.sv =====
// Binary max-heap priority queue, one push or pop per transaction.
// A push sifts the new entry up from the next free slot until it stops or reaches the root;
// a pop returns the root and sifts the last entry down until it stops or reaches a leaf.
// A push when full or a pop when empty leaves the heap as is. in_ready returns in the cycle
// after the result loads; a stalled result holds the next result, not the sift walk.
// Synchronous active-low reset empties the heap; memory contents are not cleared.
`default_nettype none

module binary_heap_priority_queue #(
  parameter int CAPACITY = bhpq_pkg::CAPACITY_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_opcode,
  input  wire logic signed [bhpq_pkg::PRIO_W-1:0] in_priority,
  input  wire logic [bhpq_pkg::TIE_W-1:0]         in_tie_key,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic signed [bhpq_pkg::PRIO_W-1:0]      out_priority,
  output logic [bhpq_pkg::TIE_W-1:0]              out_tie_key,
  output logic [bhpq_pkg::ENTRY_CNT_W-1:0]        out_entry_count,
  output logic                                    out_is_empty,
  output logic [bhpq_pkg::STAT_W-1:0]             out_status
);
  import bhpq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bhpq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_opcode       (in_opcode),
    .in_priority     (in_priority),
    .in_tie_key      (in_tie_key),
    .cmd             (cmd),
    .sts             (sts),
    .out_priority    (out_priority),
    .out_tie_key     (out_tie_key),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire

// ===== rtl/bhpq_ctrl.sv =====
// Controller for the heap queue: sequencer for push sift-up and pop sift-down.
// Depends on bhpq_pkg; drives bhpq_dpath through cmd_t and reads sts_t.
`default_nettype none

module bhpq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire bhpq_pkg::sts_t sts,
  output bhpq_pkg::cmd_t     cmd
);
  import bhpq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DEC;
        end
      end
      ST_DEC: begin
        if (sts.op_pop) begin
          if (sts.empty) begin
            cmd.set_empty = 1'b1;
            state_nxt     = ST_FIN;
          end else begin
            cmd.pop_init = 1'b1;
            state_nxt    = ST_POP_WT;
          end
        end else if (sts.full) begin
          cmd.set_full = 1'b1;
          state_nxt    = ST_FIN;
        end else begin
          cmd.push_init = 1'b1;
          state_nxt     = ST_UP_CHK;
        end
      end
      ST_UP_CHK: begin
        if (sts.pos_zero) begin
          cmd.wr_mov = 1'b1;
          state_nxt  = ST_FIN;
        end else begin
          cmd.rd_parent = 1'b1;
          state_nxt     = ST_UP_CMP;
        end
      end
      ST_UP_CMP: begin
        if (sts.up_stop) begin
          cmd.wr_mov = 1'b1;
          state_nxt  = ST_FIN;
        end else begin
          cmd.up_move = 1'b1;
          state_nxt   = ST_UP_CHK;
        end
      end
      ST_POP_WT: begin
        if (sts.empty) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.pop_load = 1'b1;
          state_nxt    = ST_DN_CHK;
        end
      end
      ST_DN_CHK: begin
        if (sts.kid_out) begin
          cmd.wr_mov = 1'b1;
          state_nxt  = ST_FIN;
        end else begin
          cmd.rd_kids = 1'b1;
          state_nxt   = ST_DN_SEL;
        end
      end
      ST_DN_SEL: begin
        cmd.dn_sel = 1'b1;
        state_nxt  = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if (sts.dn_stop) begin
          cmd.wr_mov = 1'b1;
          state_nxt  = ST_FIN;
        end else begin
          cmd.dn_move = 1'b1;
          state_nxt   = ST_DN_CHK;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== rtl/bhpq_dpath.sv =====
// Datapath for the heap queue: heap memory, fill count, root copy, sift registers
// and the result register. Depends on bhpq_pkg; commanded by bhpq_ctrl.
`default_nettype none

module bhpq_dpath #(
  parameter int CAPACITY = bhpq_pkg::CAPACITY_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_opcode,
  input  wire logic signed [bhpq_pkg::PRIO_W-1:0] in_priority,
  input  wire logic [bhpq_pkg::TIE_W-1:0]     in_tie_key,
  input  wire bhpq_pkg::cmd_t                 cmd,
  output bhpq_pkg::sts_t                      sts,
  output logic signed [bhpq_pkg::PRIO_W-1:0]  out_priority,
  output logic [bhpq_pkg::TIE_W-1:0]          out_tie_key,
  output logic [bhpq_pkg::ENTRY_CNT_W-1:0]    out_entry_count,
  output logic                                out_is_empty,
  output logic [bhpq_pkg::STAT_W-1:0]         out_status
);
  import bhpq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = AW + 2;

  entry_t mem [CAPACITY];

  logic [CW-1:0] count_r;
  logic [AW-1:0] pos_r;
  logic [AW-1:0] chpos_r;
  entry_t        mov_r, ch_r, root_r, res_r;
  entry_t        rd_a_r, rd_b_r;
  op_t           op_r;
  stat_t         stat_r;

  entry_t        out_ent_r;
  logic [CW-1:0] out_cnt_r;
  stat_t         out_stat_r;

  logic [KW-1:0] kid, kid1, cnt_x;
  logic [AW-1:0] par;
  logic [CW-1:0] cnt_m1;
  logic          right_ok;

  logic          rd_en;
  logic [AW-1:0] rd_a_addr, rd_b_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  entry_t        res_sel;

  assign kid      = {1'b0, pos_r, 1'b1};
  assign kid1     = kid + KW'(1);
  assign cnt_x    = KW'(count_r);
  assign right_ok = kid1 < cnt_x;
  assign par      = (pos_r - AW'(1)) >> 1;
  assign cnt_m1   = count_r - CW'(1);

  always_comb begin
    sts.op_pop   = (op_r == OP_POP);
    sts.full     = (count_r == CW'(CAPACITY));
    sts.empty    = (count_r == '0);
    sts.pos_zero = (pos_r == '0);
    sts.up_stop  = ranks_below(mov_r, rd_a_r);
    sts.kid_out  = (kid >= cnt_x);
    sts.dn_stop  = ranks_below(ch_r, mov_r);
  end

  // memory port selection
  always_comb begin
    rd_en     = cmd.pop_init || cmd.rd_parent || cmd.rd_kids;
    rd_a_addr = kid[AW-1:0];
    rd_b_addr = right_ok ? kid1[AW-1:0] : kid[AW-1:0];
    if (cmd.pop_init) begin
      rd_a_addr = cnt_m1[AW-1:0];
    end else if (cmd.rd_parent) begin
      rd_a_addr = par;
    end
    wr_en   = cmd.wr_mov || cmd.up_move || cmd.dn_move;
    wr_addr = pos_r;
    wr_data = mov_r;
    if (cmd.up_move) begin
      wr_data = rd_a_r;
    end else if (cmd.dn_move) begin
      wr_data = ch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= mem[rd_a_addr];
      rd_b_r <= mem[rd_b_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // root copy follows every write to slot zero
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == '0)) begin
      root_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.push_init) begin
      count_r <= count_r + CW'(1);
    end else if (cmd.pop_init) begin
      count_r <= cnt_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r       <= op_t'(in_opcode);
      stat_r     <= STAT_OK;
      mov_r.prio <= in_priority;
      mov_r.tie  <= in_tie_key;
    end
    if (cmd.set_full) begin
      stat_r <= STAT_FULL;
    end
    if (cmd.set_empty) begin
      stat_r <= STAT_EMPTY;
    end
    if (cmd.push_init) begin
      pos_r <= count_r[AW-1:0];
    end
    if (cmd.pop_init) begin
      res_r <= root_r;
    end
    if (cmd.up_move) begin
      pos_r <= par;
    end
    if (cmd.pop_load) begin
      mov_r <= rd_a_r;
      pos_r <= '0;
    end
    if (cmd.dn_sel) begin
      if (right_ok && ranks_below(rd_a_r, rd_b_r)) begin
        ch_r    <= rd_b_r;
        chpos_r <= kid1[AW-1:0];
      end else begin
        ch_r    <= rd_a_r;
        chpos_r <= kid[AW-1:0];
      end
    end
    if (cmd.dn_move) begin
      pos_r <= chpos_r;
    end
  end

  always_comb begin
    if (stat_r == STAT_EMPTY) begin
      res_sel = '0;
    end else if (op_r == OP_POP) begin
      res_sel = res_r;
    end else begin
      res_sel = root_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ent_r  <= res_sel;
      out_cnt_r  <= count_r;
      out_stat_r <= stat_r;
    end
  end

  assign out_priority    = out_ent_r.prio;
  assign out_tie_key     = out_ent_r.tie;
  assign out_entry_count = ENTRY_CNT_W'(out_cnt_r);
  assign out_is_empty    = (out_cnt_r == '0);
  assign out_status      = out_stat_r;

endmodule

`default_nettype wire

// ===== rtl/bhpq_checker.sv =====
// Port-level checker for binary_heap_priority_queue, attached by bind.
// Depends on bhpq_pkg for widths and status codes.
`default_nettype none

module bhpq_checker #(
  parameter int CAPACITY = bhpq_pkg::CAPACITY_DEF
) (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               in_opcode,
  input wire logic signed [bhpq_pkg::PRIO_W-1:0] in_priority,
  input wire logic [bhpq_pkg::TIE_W-1:0]         in_tie_key,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [bhpq_pkg::PRIO_W-1:0] out_priority,
  input wire logic [bhpq_pkg::TIE_W-1:0]         out_tie_key,
  input wire logic [bhpq_pkg::ENTRY_CNT_W-1:0]   out_entry_count,
  input wire logic                               out_is_empty,
  input wire logic [bhpq_pkg::STAT_W-1:0]        out_status
);
  import bhpq_pkg::*;

  localparam logic [ENTRY_CNT_W-1:0] FULL_CNT = ENTRY_CNT_W'(CAPACITY);

  logic unused_in;
  assign unused_in = in_opcode ^ (^in_priority) ^ (^in_tie_key);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_priority) &&
      $stable(out_tie_key) && $stable(out_status) && $stable(out_entry_count))
    else $error("result changed while stalled");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_FULL) |-> out_entry_count == FULL_CNT && !out_is_empty)
    else $error("full status with wrong count");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_EMPTY) |->
      out_is_empty && out_entry_count == '0 && out_priority == '0 && out_tie_key == '0)
    else $error("empty pop result not cleared");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind binary_heap_priority_queue bhpq_checker #(.CAPACITY(CAPACITY)) u_bhpq_checker (.*);

`default_nettype wire

// ===== tb/binary_heap_priority_queue_tb.sv =====
// Self-checking testbench for the binary max-heap priority queue: a directed table,
// then random push/pop traffic scored against an in-bench heap predictor.
// Depends on bhpq_pkg and binary_heap_priority_queue from the rtl folder.
`timescale 1ns / 100ps

module binary_heap_priority_queue_tb;
  import bhpq_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int DIR_ROWS     = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 40;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic signed [PRIO_W-1:0]  prio;
    logic [TIE_W-1:0]          tie;
    logic [ENTRY_CNT_W-1:0]    count;
    logic                      empty;
    stat_t                     status;
  } heap_result_t;

  typedef struct {
    op_t                       op;
    logic signed [PRIO_W-1:0]  prio;
    logic [TIE_W-1:0]          tie;
    bit                        typed;
    logic signed [PRIO_W-1:0]  w_prio;
    logic [TIE_W-1:0]          w_tie;
    logic [ENTRY_CNT_W-1:0]    w_count;
    stat_t                     w_status;
  } stim_row_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_opcode;
  logic signed [PRIO_W-1:0]  in_priority;
  logic [TIE_W-1:0]          in_tie_key;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [PRIO_W-1:0]  out_priority;
  logic [TIE_W-1:0]          out_tie_key;
  logic [ENTRY_CNT_W-1:0]    out_entry_count;
  logic                      out_is_empty;
  logic [STAT_W-1:0]         out_status;

  // predictor copy of the heap
  logic signed [PRIO_W-1:0]  heap_prio [CAP];
  logic [TIE_W-1:0]          heap_tie [CAP];
  int unsigned               held;

  heap_result_t              results_due [$];
  heap_result_t              blank_result;
  int                        err_count;
  int                        send_idle_pct;
  int                        recv_stall_pct;
  bit                        hold_off_req;

  stim_row_t stim_table [DIR_ROWS] = '{
    '{OP_POP,  32'sh0000_1234, 64'h0, 1, 32'sh0, 64'h0, 0, STAT_EMPTY},
    '{OP_PUSH, 32'sh7FFF_FFFF, 64'h0, 1, 32'sh7FFF_FFFF, 64'h0, 1, STAT_OK},
    '{OP_PUSH, 32'sh8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1,
      32'sh7FFF_FFFF, 64'h0, 2, STAT_OK},
    '{OP_PUSH, 32'sh0, 64'd5, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_PUSH, 32'shFFFF_FFFF, 64'h8000_0000_0000_0000, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_PUSH, 32'sh7FFF_FFFF, 64'h0, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_PUSH, 32'sh7FFF_FFFF, 64'h1, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_PUSH, 32'sh0, 64'd5, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_PUSH, 32'sh0, 64'd4, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_PUSH, 32'sh0, 64'd6, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_PUSH, 32'sh8000_0000, 64'h0, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_PUSH, 32'sh5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_POP,  32'shFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_POP,  32'sh0, 64'h0, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_POP,  32'sh0, 64'h0, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_POP,  32'sh0, 64'h0, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_POP,  32'sh0, 64'h0, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_POP,  32'sh0, 64'h0, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_POP,  32'sh0, 64'h0, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_POP,  32'sh0, 64'h0, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_POP,  32'sh0, 64'h0, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_POP,  32'sh0, 64'h0, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_POP,  32'sh0, 64'h0, 0, 32'sh0, 64'h0, 0, STAT_OK},
    '{OP_POP,  32'sh7FFF_FFFF, 64'h1, 1, 32'sh0, 64'h0, 0, STAT_EMPTY}
  };

  binary_heap_priority_queue dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_priority     (in_priority),
    .in_tie_key      (in_tie_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_priority    (out_priority),
    .out_tie_key     (out_tie_key),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_status      (out_status)
  );

  // a strictly below b: lower priority, or same priority with the larger tie key
  function automatic bit ranks_lower(logic signed [PRIO_W-1:0] pa, logic [TIE_W-1:0] ta,
                                     logic signed [PRIO_W-1:0] pb, logic [TIE_W-1:0] tb);
    return (pa < pb) || ((pa == pb) && (ta > tb));
  endfunction

  function automatic heap_result_t apply_heap_op(op_t op, logic signed [PRIO_W-1:0] p,
                                                 logic [TIE_W-1:0] t);
    heap_result_t             r;
    int unsigned              pos;
    int unsigned              nxt;
    logic signed [PRIO_W-1:0] mp;
    logic [TIE_W-1:0]         mt;
    r.prio   = '0;
    r.tie    = '0;
    r.status = STAT_OK;
    if (op == OP_PUSH) begin
      if (held >= CAP) begin
        r.status = STAT_FULL;
      end else begin
        pos = held;
        held++;
        while (pos > 0) begin
          nxt = (pos - 1) / 2;
          if (ranks_lower(p, t, heap_prio[nxt], heap_tie[nxt])) break;
          heap_prio[pos] = heap_prio[nxt];
          heap_tie[pos]  = heap_tie[nxt];
          pos = nxt;
        end
        heap_prio[pos] = p;
        heap_tie[pos]  = t;
      end
      if (held > 0) begin
        r.prio = heap_prio[0];
        r.tie  = heap_tie[0];
      end
    end else if (held == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      r.prio = heap_prio[0];
      r.tie  = heap_tie[0];
      held--;
      mp  = heap_prio[held];
      mt  = heap_tie[held];
      pos = 0;
      while (2 * pos + 1 < held) begin
        nxt = 2 * pos + 1;
        if (nxt + 1 < held &&
            ranks_lower(heap_prio[nxt], heap_tie[nxt], heap_prio[nxt+1], heap_tie[nxt+1]))
          nxt++;
        if (ranks_lower(heap_prio[nxt], heap_tie[nxt], mp, mt)) break;
        heap_prio[pos] = heap_prio[nxt];
        heap_tie[pos]  = heap_tie[nxt];
        pos = nxt;
      end
      heap_prio[pos] = mp;
      heap_tie[pos]  = mt;
    end
    r.count = held[ENTRY_CNT_W-1:0];
    r.empty = (held == 0);
    return r;
  endfunction

  function automatic logic signed [PRIO_W-1:0] rand_prio();
    case ($urandom_range(0, 5))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return $signed($urandom_range(0, 6)) - 3;
      3:       return 32'sh0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [TIE_W-1:0] rand_tie();
    case ($urandom_range(0, 5))
      0:       return 64'h0;
      1:       return 64'hFFFF_FFFF_FFFF_FFFF;
      2:       return 64'($urandom_range(0, 3));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic void note_failure(string msg);
    err_count++;
    if (err_count <= REPORT_LIMIT) $display("mismatch at %0t ns: %s", $time, msg);
  endfunction

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic drive_item(op_t op, logic signed [PRIO_W-1:0] p, logic [TIE_W-1:0] t,
                            bit typed, heap_result_t want);
    heap_result_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_priority <= p;
    in_tie_key  <= t;
    do @(posedge clk); while (!in_ready);
    got = apply_heap_op(op, p, t);
    results_due.push_back(typed ? want : got);
  endtask

  task automatic run_random(int n, int push_pct);
    op_t op;
    repeat (n) begin
      op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      drive_item(op, rand_prio(), rand_tie(), 1'b0, blank_result);
    end
  endtask

  task automatic fill_to_full(int extra);
    while (held < CAP) drive_item(OP_PUSH, rand_prio(), rand_tie(), 1'b0, blank_result);
    repeat (extra) drive_item(OP_PUSH, rand_prio(), rand_tie(), 1'b0, blank_result);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result side: random stalls plus a long hold-off when requested
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        note_failure("result transaction with nothing outstanding");
      end else begin
        want = results_due.pop_front();
        if (out_priority !== want.prio)
          note_failure($sformatf("priority exp %0d got %0d", want.prio, out_priority));
        if (out_tie_key !== want.tie)
          note_failure($sformatf("tie key exp %h got %h", want.tie, out_tie_key));
        if (out_entry_count !== want.count)
          note_failure($sformatf("count exp %0d got %0d", want.count, out_entry_count));
        if (out_is_empty !== want.empty)
          note_failure($sformatf("empty exp %0b got %0b", want.empty, out_is_empty));
        if (out_status !== want.status)
          note_failure($sformatf("status exp %0d got %0d", want.status, out_status));
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    heap_result_t want;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_opcode    = OP_PUSH;
    in_priority  = '0;
    in_tie_key   = '0;
    held         = 0;
    err_count    = 0;
    hold_off_req = 1'b0;
    set_idling(0, 0);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_table[i]) begin
      want.prio   = stim_table[i].w_prio;
      want.tie    = stim_table[i].w_tie;
      want.count  = stim_table[i].w_count;
      want.empty  = (stim_table[i].w_count == 0);
      want.status = stim_table[i].w_status;
      drive_item(stim_table[i].op, stim_table[i].prio, stim_table[i].tie,
                 stim_table[i].typed, want);
    end

    // back-pressure: output held off while random items are offered at the input
    hold_off_req = 1'b1;
    run_random(300, 60);

    set_idling(76, 0);
    run_random(250, 35);
    wait_drained();

    set_idling(0, 76);
    fill_to_full(8);
    run_random(20, 50);

    set_idling(9, 9);
    run_random(200, 30);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
